>>> hw/rtl/bbp_pkg.sv
// Shared types and constants for the board bitmap packer.
package bbp_pkg;
  localparam int unsigned SQUARES = 64;
  localparam logic [6:0] VAR_PAYLOAD = 7'h7F;
  localparam logic [7:0] VAR_MORE = 8'h80;
  localparam logic [3:0] EP_NONE = 4'd8;

  typedef struct packed {
    logic [63:0] occupied_map;
    logic [63:0] white_map;
    logic [63:0] pawn_map;
    logic [63:0] knight_map;
    logic [63:0] bishop_map;
    logic [63:0] rook_map;
    logic [63:0] queen_map;
    logic        side_white;
    logic [3:0]  castle_rights;
    logic [3:0]  ep_column;
    logic [63:0] halfmove_count;
    logic [63:0] fullmove_count;
  } pos_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        last_word;
    logic [9:0]  total_bits;
    logic [6:0]  total_bytes;
    logic [6:0]  piece_count;
  } word_t;

  // Front-end job handed to the back end: one bit-field to emit.
  // A job is either a raw field (value, length) or a masked extract.
  typedef struct packed {
    logic [63:0] value;
    logic [63:0] mask;
    logic [6:0]  len;
    logic        extract;
    logic        last;
    logic [6:0]  piece_count;
  } job_t;
endpackage

>>> hw/rtl/bbp_stream_if.sv
// Valid/ready channel carrying a payload of a given type.
interface bbp_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/bbp_front.sv
// Front end: accepts a position and issues one field job a cycle while job_ready is high.
module bbp_front import bbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bbp_stream_if.sink   pos_in,
  output logic         job_valid,
  output job_t         job,
  input  logic         job_ready
);
  typedef enum logic [1:0] {IDLE, FIELDS, HALF, FULL} state_t;
  state_t      state;
  pos_t        p;
  logic [3:0]  idx;
  logic [63:0] rem;
  logic [63:0] vint;
  logic [6:0]  npc;
  logic [6:0]  pcount;

  // Occupancy popcount, one byte per field cycle in which job_ready is high; complete before the varint jobs
  always_comb begin
    npc = '0;
    for (int i = 0; i < 8; i++) npc = npc + 7'(p.occupied_map[{idx[2:0], 3'(i)}]);
  end

  assign pos_in.ready = (state == IDLE);

  // One varint byte per cycle from vint while job_ready is high
  logic [7:0]  vbyte;
  logic        vmore;
  assign vmore = (vint[63:7] != '0);
  assign vbyte = {vmore, vint[6:0] & VAR_PAYLOAD} | (vmore ? VAR_MORE : 8'h00);

  always_comb begin
    job = '0;
    job.piece_count = pcount;
    job_valid = (state != IDLE);
    case (state)
      FIELDS: begin
        case (idx)
          4'd0: begin job.value = p.occupied_map; job.len = 7'd64; end
          4'd1: begin job.value = p.white_map; job.mask = p.occupied_map; job.extract = 1'b1; end
          4'd2: begin job.value = p.pawn_map; job.mask = p.occupied_map; job.extract = 1'b1; end
          4'd3: begin job.value = p.knight_map; job.mask = rem; job.extract = 1'b1; end
          4'd4: begin job.value = p.bishop_map; job.mask = rem; job.extract = 1'b1; end
          4'd5: begin job.value = p.rook_map; job.mask = rem; job.extract = 1'b1; end
          4'd6: begin job.value = p.queen_map; job.mask = rem; job.extract = 1'b1; end
          default: begin
            if (p.ep_column < EP_NONE) begin
              job.value = {55'd0, p.ep_column[2:0], 1'b1, p.castle_rights, p.side_white};
              job.len = 7'd9;
            end else begin
              job.value = {58'd0, 1'b0, p.castle_rights, p.side_white};
              job.len = 7'd6;
            end
          end
        endcase
      end
      HALF, FULL: begin
        job.value = {56'd0, vbyte};
        job.len = 7'd8;
        job.last = (state == FULL) && !vmore;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: if (pos_in.valid) begin
          p <= pos_in.data;
          pcount <= '0;
          idx <= '0;
          rem <= pos_in.data.occupied_map & ~pos_in.data.pawn_map;
          state <= FIELDS;
        end
        FIELDS: if (job_ready) begin
          pcount <= pcount + npc;
          if (idx >= 4'd3) rem <= rem & ~job.value;
          if (idx == 4'd7) begin
            vint <= p.halfmove_count;
            state <= HALF;
          end
          idx <= idx + 4'd1;
        end
        HALF: if (job_ready) begin
          vint <= vint >> 7;
          if (!vmore) begin
            vint <= p.fullmove_count;
            state <= FULL;
          end
        end
        FULL: if (job_ready) begin
          vint <= vint >> 7;
          if (!vmore) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && job_valid && job.extract) begin
      assert (job.mask != '0 || job.len == '0) else $error("extract job has length");
    end
  end
  assert property (@(posedge clk) disable iff (rst)
    (state == FULL && job_ready && !vmore) |=> state == IDLE) else $error("front did not finish");
  assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !job_valid) else $error("job while idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == FIELDS) |-> idx <= 4'd7) else $error("field index overrun");
endmodule

>>> hw/rtl/bbp_fifo.sv
// Short job queue between front and back ends.
module bbp_fifo import bbp_pkg::*; #(parameter int unsigned Depth = 4) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  job_t in_data,
  output logic in_ready,
  output logic out_valid,
  output job_t out_data,
  input  logic out_ready
);
  localparam int unsigned AW = $clog2(Depth);
  job_t            mem [Depth];
  logic [AW-1:0]   wp, rp;
  logic [AW:0]     cnt;
  logic            push, pop;

  assign in_ready = (cnt != (AW+1)'(Depth));
  assign out_valid = (cnt != '0);
  assign out_data = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
  always_ff @(posedge clk) if (push) mem[wp] <= in_data;

  assert property (@(posedge clk) disable iff (rst) cnt <= (AW+1)'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (cnt == '0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 1'b1) else $error("count slip");
endmodule

>>> hw/rtl/bbp_back.sv
// Back end: bit-extracts fields, packs bits and emits 64-bit words.
module bbp_back import bbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_ready,
  bbp_stream_if.source word_out
);
  // Extract: walk the mask 8 bits a cycle, collecting selected bits.
  typedef enum logic [1:0] {IDLE, EXTR, PUT, FLUSH} state_t;
  state_t      state;
  logic [63:0] val, msk, acc;
  logic [6:0]  alen;
  logic [2:0]  chunk;
  logic        last_f;
  logic [6:0]  pc;
  logic [127:0] buff;   // pending bits, LSB first
  logic [7:0]  bcnt;
  logic [9:0]  tbits;
  logic [6:0]  tbytes;

  // one 8-bit chunk of extraction
  logic [63:0] acc_n;
  logic [6:0]  alen_n;
  always_comb begin
    acc_n = acc;
    alen_n = alen;
    for (int i = 0; i < 8; i++) begin
      if (msk[{chunk, 3'(i)}]) begin
        acc_n[alen_n[5:0]] = val[{chunk, 3'(i)}];
        alen_n = alen_n + 7'd1;
      end
    end
  end

  logic word_full;
  assign word_full = (bcnt >= 8'd64);
  assign job_ready = (state == IDLE) && !word_full;

  always_comb begin
    word_out.data = '0;
    word_out.data.out_word = buff[63:0];
    if (state == FLUSH) begin
      word_out.data.byte_count = (bcnt >= 8'd64) ? 4'd8 : 4'((bcnt + 8'd7) >> 3);
      word_out.data.last_word = (bcnt <= 8'd64);
      if (bcnt <= 8'd64) begin
        word_out.data.total_bits = tbits;
        word_out.data.total_bytes = tbytes;
        word_out.data.piece_count = pc;
        word_out.data.out_word = buff[63:0];
      end
    end else begin
      word_out.data.byte_count = 4'd8;
    end
  end
  assign word_out.valid = word_full || (state == FLUSH);

  logic [127:0] ins;
  assign ins = 128'(acc & ((alen == 7'd64) ? '1 : ((64'd1 << alen[5:0]) - 64'd1))) << bcnt[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      bcnt <= '0;
      buff <= '0;
      tbits <= '0;
    end else begin
      if (word_out.valid && word_out.ready) begin
        if (state == FLUSH && bcnt <= 8'd64) begin
          buff <= '0; bcnt <= '0; tbits <= '0; state <= IDLE;
        end else begin
          buff <= buff >> 64; bcnt <= bcnt - 8'd64;
        end
      end else begin
        case (state)
          IDLE: if (job_valid && job_ready) begin
            val <= job.value; last_f <= job.last; pc <= job.piece_count;
            if (job.extract) begin
              msk <= job.mask; acc <= '0; alen <= '0; chunk <= '0; state <= EXTR;
            end else begin
              acc <= job.value; alen <= job.len; state <= PUT;
            end
          end
          EXTR: begin
            acc <= acc_n; alen <= alen_n; chunk <= chunk + 3'd1;
            if (chunk == 3'd7) state <= PUT;
          end
          PUT: begin
            buff <= buff | ins;
            bcnt <= bcnt + 8'(alen);
            tbits <= tbits + 10'(alen);
            tbytes <= 7'((tbits + 10'(alen) + 10'd7) >> 3);
            state <= last_f ? FLUSH : IDLE;
          end
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) bcnt <= 8'd127)
    else $error("pack buffer overflow");
  assert property (@(posedge clk) disable iff (rst)
    (word_out.valid && word_out.data.last_word) |-> state == FLUSH) else $error("stray last");
  assert property (@(posedge clk) disable iff (rst)
    (state == EXTR && chunk == 3'd7) |=> state == PUT || word_out.valid) else $error("extract");
endmodule

>>> hw/rtl/board_bitmap_packer_core.sv
// Top level of the board bitmap packer.
// One position is taken per transfer on pos_in and packed LSB-first into a
// bit stream, sent as 2 to 10 transfers of 64-bit words on word_out; the last
// word carries total_bits, total_bytes and piece_count. The front end issues
// one field per cycle while the queue has room (occupancy, six piece
// extracts, flags, one varint byte per cycle); extracts pass through the
// back end's 8-bit-a-cycle bit-extract unit, and the back end takes a new
// job only when idle with no full word waiting. A new position is accepted
// once the front end has issued all fields of the previous one.
module board_bitmap_packer_core import bbp_pkg::*; #(parameter int unsigned QueueDepth = 4) (
  input  logic         clk,
  input  logic         rst,
  bbp_stream_if.sink   pos_in,
  bbp_stream_if.source word_out
);
  logic job_valid_f, job_ready_f, job_valid_b, job_ready_b;
  job_t job_f, job_b;

  bbp_front u_front (
    .clk(clk), .rst(rst), .pos_in(pos_in),
    .job_valid(job_valid_f), .job(job_f), .job_ready(job_ready_f)
  );

  bbp_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(job_valid_f), .in_data(job_f), .in_ready(job_ready_f),
    .out_valid(job_valid_b), .out_data(job_b), .out_ready(job_ready_b)
  );

  bbp_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(job_valid_b), .job(job_b), .job_ready(job_ready_b),
    .word_out(word_out)
  );
endmodule
